[hdl/assert_macros.svh]
// Assertion helpers used by the checker file sdb_checker.sv.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset
`define SDB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, gated off during reset
`define SDB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/sdb_pkg.sv]
// ----------------------------------------------------------------------------
// sdb_pkg
// Shared types and constants of the step delta splitter with backlash
// compensation: widths, register indexes, opcodes and lane control.
// ----------------------------------------------------------------------------
package sdb_pkg;

  localparam int unsigned NumSteppers = 4;
  localparam int unsigned PosW        = 32;
  localparam int unsigned BlW         = 16;
  localparam int unsigned LeadW       = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned NumPairs    = (NumSteppers + 1) / 2;

  typedef logic [PosW-1:0]        sdb_pos_t;
  typedef logic [BlW-1:0]         sdb_bl_t;
  typedef logic [LeadW-1:0]       sdb_lead_t;
  typedef logic [NumSteppers-1:0] sdb_mask_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegCheckMode  = 3'd0,
    RegBacklashEn = 3'd1,
    RegBacklash0  = 3'd2,
    RegBacklash1  = 3'd3,
    RegBacklash2  = 3'd4,
    RegBacklash3  = 3'd5
  } sdb_reg_e;

  // Input opcodes
  typedef enum logic {
    OpMove = 1'b0,
    OpSync = 1'b1
  } sdb_op_e;

  // Stage load strobes from the top level to every lane
  typedef struct packed {
    logic in_load;  // input transfer: latch target, form delta
    logic s2_load;  // delta stage advances: form counts
  } sdb_lane_ctrl_t;

endpackage

[hdl/sdb_lane.sv]
// ----------------------------------------------------------------------------
// sdb_lane
// One stepper lane: stored position, wrapped delta, absolute step count and
// the backlash compensation count for a flipped direction.
// ----------------------------------------------------------------------------
module sdb_lane import sdb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sdb_lane_ctrl_t         ctrl_i,
  input  logic signed [PosW-1:0] target_i,
  input  sdb_bl_t                bl_steps_i,
  input  logic                   flip_i,
  output logic                   dir_o,
  output logic                   moving_o,
  output sdb_pos_t               count_o,
  output sdb_bl_t                bcnt_o
);

  sdb_pos_t pos_q;
  sdb_pos_t delta_q;
  sdb_pos_t count_d, count_q;
  sdb_bl_t  bcnt_d, bcnt_q;

  // Load the stored position on every transfer; a still lane stores its own value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (ctrl_i.in_load) begin
      pos_q <= sdb_pos_t'(target_i);
    end
  end

  // Form the wrapped delta against the stored position
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_load) begin
      delta_q <= sdb_pos_t'(target_i) - pos_q;
    end
  end

  assign dir_o    = delta_q[PosW-1];
  assign moving_o = |delta_q;

  // Take the magnitude; the most negative delta maps onto 2^31
  always_comb begin
    count_d = dir_o ? (sdb_pos_t'(0) - delta_q) : delta_q;
    bcnt_d  = flip_i ? bl_steps_i : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_load) begin
      count_q <= count_d;
      bcnt_q  <= bcnt_d;
    end
  end

  assign count_o = count_q;
  assign bcnt_o  = bcnt_q;

endmodule

[hdl/sdb_merge.sv]
// ----------------------------------------------------------------------------
// sdb_merge
// Merge stage: registered pairwise compare of the lane counts, then a final
// compare that yields the longest count and lead stepper, for the move
// counts and for the compensation counts. Ties go to the higher index.
// ----------------------------------------------------------------------------
module sdb_merge import sdb_pkg::*; (
  input  logic      clk_i,
  input  logic      load_i,
  input  sdb_pos_t  count_i     [NumSteppers],
  input  sdb_bl_t   bcnt_i      [NumSteppers],
  output sdb_pos_t  count_o     [NumSteppers],
  output sdb_bl_t   bcnt_o      [NumSteppers],
  output sdb_pos_t  longest_o,
  output sdb_lead_t lead_o,
  output sdb_bl_t   bl_longest_o,
  output sdb_lead_t bl_lead_o
);

  sdb_pos_t  pair_val_d  [NumPairs];
  sdb_lead_t pair_idx_d  [NumPairs];
  sdb_bl_t   bpair_val_d [NumPairs];
  sdb_lead_t bpair_idx_d [NumPairs];
  sdb_pos_t  pair_val_q  [NumPairs];
  sdb_lead_t pair_idx_q  [NumPairs];
  sdb_bl_t   bpair_val_q [NumPairs];
  sdb_lead_t bpair_idx_q [NumPairs];
  sdb_pos_t  count_q     [NumSteppers];
  sdb_bl_t   bcnt_q      [NumSteppers];
  sdb_pos_t  longest;
  sdb_lead_t lead;
  sdb_bl_t   bl_longest;
  sdb_lead_t bl_lead;

  // First level: the higher lane of a pair wins unless the lower is larger
  always_comb begin
    for (int p = 0; p < NumPairs; p++) begin
      pair_val_d[p]  = count_i[2*p];
      pair_idx_d[p]  = sdb_lead_t'(2*p);
      bpair_val_d[p] = bcnt_i[2*p];
      bpair_idx_d[p] = sdb_lead_t'(2*p);
      if (2*p + 1 < NumSteppers) begin
        if (!(count_i[2*p] > count_i[2*p+1])) begin
          pair_val_d[p] = count_i[2*p+1];
          pair_idx_d[p] = sdb_lead_t'(2*p + 1);
        end
        if (!(bcnt_i[2*p] > bcnt_i[2*p+1])) begin
          bpair_val_d[p] = bcnt_i[2*p+1];
          bpair_idx_d[p] = sdb_lead_t'(2*p + 1);
        end
      end
    end
  end

  // Hold pair winners and the lane counts alongside
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_val_q  <= pair_val_d;
      pair_idx_q  <= pair_idx_d;
      bpair_val_q <= bpair_val_d;
      bpair_idx_q <= bpair_idx_d;
      count_q     <= count_i;
      bcnt_q      <= bcnt_i;
    end
  end

  // Final level over the pair winners, higher pair wins ties
  always_comb begin
    longest    = pair_val_q[0];
    lead       = pair_idx_q[0];
    bl_longest = bpair_val_q[0];
    bl_lead    = bpair_idx_q[0];
    for (int p = 1; p < NumPairs; p++) begin
      if (!(longest > pair_val_q[p])) begin
        longest = pair_val_q[p];
        lead    = pair_idx_q[p];
      end
      if (!(bl_longest > bpair_val_q[p])) begin
        bl_longest = bpair_val_q[p];
        bl_lead    = bpair_idx_q[p];
      end
    end
  end

  assign count_o      = count_q;
  assign bcnt_o       = bcnt_q;
  assign longest_o    = longest;
  assign lead_o       = lead;
  assign bl_longest_o = bl_longest;
  // No compensation steps at all: fall back on the move's lead stepper
  assign bl_lead_o    = (bl_longest == '0) ? lead : bl_lead;

endmodule

[hdl/step_delta_backlash_splitter.sv]
// ----------------------------------------------------------------------------
// step_delta_backlash_splitter
// Splits absolute step targets for four steppers into move blocks, inserting
// a backlash compensation block ahead of a move whose directions flip.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   opcode, target_0..3
//   out      output     out_valid_o / out_stall_i block fields, last_of_run
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A move yields one block in the output register, two when a compensation
// block goes ahead of it; sync items and moves that emit nothing yield no
// block. From input transfer to the first block shown, an item passes the
// count, pair compare and output registers (the delta register loads with
// the transfer itself). Reset clears the stored positions, the direction
// history, the stage valids and the configuration registers. A stall on the
// output holds the block and backs up through the stages to in_stall_o.
// ----------------------------------------------------------------------------
module step_delta_backlash_splitter import sdb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic signed [PosW-1:0] target_0_i,
  input  logic signed [PosW-1:0] target_1_i,
  input  logic signed [PosW-1:0] target_2_i,
  input  logic signed [PosW-1:0] target_3_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_compensation_o,
  output logic [PosW-1:0]        count_0_o,
  output logic [PosW-1:0]        count_1_o,
  output logic [PosW-1:0]        count_2_o,
  output logic [PosW-1:0]        count_3_o,
  output logic [NumSteppers-1:0] direction_mask_o,
  output logic [PosW-1:0]        longest_count_o,
  output logic [LeadW-1:0]       lead_stepper_o,
  output logic                   last_of_run_o
);

  // configuration registers
  logic      check_mode_q;
  logic      bl_en_q;
  sdb_bl_t   bl_steps_q [NumSteppers];

  // pipeline control
  logic      s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic      s2_comp_q, s3_comp_q;
  sdb_mask_t prev_dir_q;
  sdb_mask_t s2_dir_q, s3_dir_q;

  // output register
  logic      out_comp_q;
  sdb_pos_t  out_count_q [NumSteppers];
  sdb_mask_t out_dir_q;
  sdb_pos_t  out_longest_q;
  sdb_lead_t out_lead_q;
  logic      out_last_q;

  // lane and merge wiring
  logic signed [PosW-1:0] target [NumSteppers];
  sdb_lane_ctrl_t lane_ctrl;
  sdb_mask_t      lane_dir, lane_moving, lane_flip;
  sdb_pos_t       lane_count [NumSteppers];
  sdb_bl_t        lane_bcnt  [NumSteppers];
  sdb_pos_t       mrg_count  [NumSteppers];
  sdb_bl_t        mrg_bcnt   [NumSteppers];
  sdb_pos_t       mrg_longest;
  sdb_lead_t      mrg_lead;
  sdb_bl_t        mrg_bl_longest;
  sdb_lead_t      mrg_bl_lead;

  logic in_xfer, out_xfer, out_free, out_load;
  logic s3_done, s3_take, s2_adv, s2_take, s1_adv, s1_take;
  logic s1_keep, s1_comp;

  assign target[0] = target_0_i;
  assign target[1] = target_1_i;
  assign target[2] = target_2_i;
  assign target[3] = target_3_i;

  // Handshake and stage advance
  assign out_xfer = out_valid_q & ~out_stall_i;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign out_load = s3_valid_q & out_free;
  assign s3_done  = out_load & ~s3_comp_q;
  assign s3_take  = ~s3_valid_q | s3_done;
  assign s2_adv   = s2_valid_q & s3_take;
  assign s2_take  = ~s2_valid_q | s2_adv;
  assign s1_adv   = s1_valid_q & s2_take;
  assign s1_take  = ~s1_valid_q | s1_adv;
  assign in_stall_o = ~s1_take;
  assign in_xfer    = in_valid_i & s1_take;

  // Drop a still move or any move in check mode; flag a direction flip
  assign s1_keep   = (|lane_moving) & ~check_mode_q;
  assign lane_flip = prev_dir_q ^ lane_dir;
  assign s1_comp   = s1_keep & bl_en_q & (|lane_flip);

  assign lane_ctrl.in_load = in_xfer;
  assign lane_ctrl.s2_load = s1_adv;

  for (genvar g = 0; g < NumSteppers; g++) begin : g_lane
    sdb_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .target_i   (target[g]),
      .bl_steps_i (bl_steps_q[g]),
      .flip_i     (lane_flip[g]),
      .dir_o      (lane_dir[g]),
      .moving_o   (lane_moving[g]),
      .count_o    (lane_count[g]),
      .bcnt_o     (lane_bcnt[g])
    );
  end

  sdb_merge u_merge (
    .clk_i        (clk_i),
    .load_i       (s2_adv),
    .count_i      (lane_count),
    .bcnt_i       (lane_bcnt),
    .count_o      (mrg_count),
    .bcnt_o       (mrg_bcnt),
    .longest_o    (mrg_longest),
    .lead_o       (mrg_lead),
    .bl_longest_o (mrg_bl_longest),
    .bl_lead_o    (mrg_bl_lead)
  );

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q <= 1'b0;
      bl_en_q      <= 1'b0;
      for (int i = 0; i < NumSteppers; i++) begin
        bl_steps_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (sdb_reg_e'(cfg_index_i))
        RegCheckMode:  check_mode_q  <= cfg_data_i[0];
        RegBacklashEn: bl_en_q       <= cfg_data_i[0];
        RegBacklash0:  bl_steps_q[0] <= sdb_bl_t'(cfg_data_i);
        RegBacklash1:  bl_steps_q[1] <= sdb_bl_t'(cfg_data_i);
        RegBacklash2:  bl_steps_q[2] <= sdb_bl_t'(cfg_data_i);
        RegBacklash3:  bl_steps_q[3] <= sdb_bl_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Advance stage valids, flags and the direction history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_comp_q   <= 1'b0;
      s3_valid_q  <= 1'b0;
      s3_comp_q   <= 1'b0;
      out_valid_q <= 1'b0;
      prev_dir_q  <= '0;
    end else begin
      if (s1_take) begin
        s1_valid_q <= in_xfer & (sdb_op_e'(opcode_i) == OpMove);
      end
      if (s1_adv) begin
        s2_valid_q <= s1_keep;
        s2_comp_q  <= s1_comp;
        if (s1_comp) begin
          prev_dir_q <= lane_dir;
        end
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        s3_valid_q <= 1'b1;
        s3_comp_q  <= s2_comp_q;
      end else if (s3_done) begin
        s3_valid_q <= 1'b0;
      end else if (out_load) begin
        s3_comp_q  <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold direction masks alongside the stages
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_dir_q <= lane_dir;
    end
    if (s2_adv) begin
      s3_dir_q <= s2_dir_q;
    end
  end

  // Load the output register: compensation block first, then the move block
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dir_q <= s3_dir_q;
      if (s3_comp_q) begin
        out_comp_q    <= 1'b1;
        out_longest_q <= sdb_pos_t'(mrg_bl_longest);
        out_lead_q    <= mrg_bl_lead;
        out_last_q    <= 1'b0;
        for (int i = 0; i < NumSteppers; i++) begin
          out_count_q[i] <= sdb_pos_t'(mrg_bcnt[i]);
        end
      end else begin
        out_comp_q    <= 1'b0;
        out_longest_q <= mrg_longest;
        out_lead_q    <= mrg_lead;
        out_last_q    <= 1'b1;
        out_count_q   <= mrg_count;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign is_compensation_o = out_comp_q;
  assign count_0_o         = out_count_q[0];
  assign count_1_o         = out_count_q[1];
  assign count_2_o         = out_count_q[2];
  assign count_3_o         = out_count_q[3];
  assign direction_mask_o  = out_dir_q;
  assign longest_count_o   = out_longest_q;
  assign lead_stepper_o    = out_lead_q;
  assign last_of_run_o     = out_last_q;

endmodule

[hdl/sdb_checker.sv]
// ----------------------------------------------------------------------------
// sdb_checker
// Port-level checks on the splitter: block ordering within a run, range of
// compensation counts, and output hold under stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        is_compensation_o,
  input logic [3:0]  direction_mask_o,
  input logic [31:0] longest_count_o,
  input logic        last_of_run_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // A compensation block never closes a run, a move block always does
  `SDB_ASSERT_SAME(a_run_end, out_valid_o, is_compensation_o != last_of_run_o)

  // The move block follows its compensation block at once, same directions
  `SDB_ASSERT_NEXT(a_move_follows, out_xfer && is_compensation_o,
    out_valid_o && !is_compensation_o && direction_mask_o == $past(direction_mask_o))

  // A move block always carries motion
  `SDB_ASSERT_SAME(a_move_nonzero, out_valid_o && !is_compensation_o,
    longest_count_o != 32'd0)

  // Compensation counts stay within sixteen bits
  `SDB_ASSERT_SAME(a_comp_range, out_valid_o && is_compensation_o,
    longest_count_o[31:16] == 16'd0)

  // A stalled block holds
  `SDB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(longest_count_o) && $stable(last_of_run_o))

endmodule

bind step_delta_backlash_splitter sdb_checker u_sdb_checker (.*);

[tb/sdb_block_checker.sv]
// ----------------------------------------------------------------------------
// sdb_block_checker
// Watches the configuration port and both channels of the step delta
// splitter. It keeps its own copy of the stored positions, the direction
// history and the registers, and works out the blocks that each input
// transfer must cause. Each output transfer is compared field by field with
// the oldest block still due. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module sdb_block_checker import sdb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration port
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   opcode_i,
  input  logic [PosW-1:0]        target_0_i,
  input  logic [PosW-1:0]        target_1_i,
  input  logic [PosW-1:0]        target_2_i,
  input  logic [PosW-1:0]        target_3_i,
  // output channel
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic                   is_compensation_i,
  input  logic [PosW-1:0]        count_0_i,
  input  logic [PosW-1:0]        count_1_i,
  input  logic [PosW-1:0]        count_2_i,
  input  logic [PosW-1:0]        count_3_i,
  input  logic [NumSteppers-1:0] direction_mask_i,
  input  logic [PosW-1:0]        longest_count_i,
  input  logic [LeadW-1:0]       lead_stepper_i,
  input  logic                   last_of_run_i,
  // results
  output int unsigned            mismatch_count_o,
  output int unsigned            blocks_due_o,
  output int unsigned            blocks_seen_o,
  output int unsigned            comp_seen_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NumSteppers-1:0][PosW-1:0] pos_vec_t;

  typedef struct packed {
    logic      comp;
    pos_vec_t  counts;
    sdb_mask_t dir;
    sdb_pos_t  longest;
    sdb_lead_t lead;
    logic      last;
  } motion_block_t;

  // Mirrored block state and registers
  pos_vec_t                      position_q;
  sdb_mask_t                     prev_dir_q;
  logic                          check_mode_q;
  logic                          backlash_en_q;
  logic [NumSteppers-1:0][BlW-1:0] backlash_q;

  motion_block_t blocks_due[$];

  // Compare one field and count a mismatch
  task automatic check_field(input string name, input logic [PosW-1:0] want,
                             input logic [PosW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatch_count_o++;
    end
  endtask

  // Work out the blocks caused by one input transfer and update the state
  task automatic split_into_blocks(input logic op, input pos_vec_t tgt);
    pos_vec_t      cnt;
    pos_vec_t      comp_cnt;
    sdb_pos_t      delta;
    sdb_pos_t      longest;
    sdb_pos_t      comp_longest;
    sdb_lead_t     lead;
    sdb_lead_t     comp_lead;
    sdb_mask_t     dir;
    sdb_mask_t     flip;
    motion_block_t blk;
    if (op == OpSync) begin
      position_q = tgt;
      return;
    end
    dir     = '0;
    longest = '0;
    lead    = '0;
    // Scan from the top stepper down so that ties land on the highest index
    for (int i = NumSteppers - 1; i >= 0; i--) begin
      delta = tgt[i] - position_q[i];
      if (delta[PosW-1]) begin
        dir[i] = 1'b1;
        cnt[i] = '0 - delta;
      end else begin
        cnt[i] = delta;
      end
      if (longest < cnt[i]) begin
        longest = cnt[i];
        lead    = sdb_lead_t'(i);
      end
    end
    // Drop a move with no motion
    if (longest == '0) return;
    position_q = tgt;
    if (check_mode_q) return;
    // Insert the compensation block on a direction flip
    if (backlash_en_q && (prev_dir_q != dir)) begin
      flip         = prev_dir_q ^ dir;
      comp_longest = '0;
      comp_lead    = lead;
      for (int i = NumSteppers - 1; i >= 0; i--) begin
        comp_cnt[i] = flip[i] ? sdb_pos_t'(backlash_q[i]) : '0;
        if (comp_longest < comp_cnt[i]) begin
          comp_longest = comp_cnt[i];
          comp_lead    = sdb_lead_t'(i);
        end
      end
      blk = '{comp: 1'b1, counts: comp_cnt, dir: dir, longest: comp_longest,
              lead: comp_lead, last: 1'b0};
      blocks_due.push_back(blk);
      prev_dir_q = dir;
    end
    blk = '{comp: 1'b0, counts: cnt, dir: dir, longest: longest, lead: lead,
            last: 1'b1};
    blocks_due.push_back(blk);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motion_block_t blk;
    if (!rst_ni) begin
      position_q       = '0;
      prev_dir_q       = '0;
      check_mode_q     = 1'b0;
      backlash_en_q    = 1'b0;
      backlash_q       = '0;
      blocks_due.delete();
      mismatch_count_o = 0;
      blocks_due_o     = 0;
      blocks_seen_o    = 0;
      comp_seen_o      = 0;
    end else begin
      // Track register writes; unknown indexes are ignored
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegCheckMode:  check_mode_q  = cfg_data_i[0];
          RegBacklashEn: backlash_en_q = cfg_data_i[0];
          RegBacklash0:  backlash_q[0] = cfg_data_i[BlW-1:0];
          RegBacklash1:  backlash_q[1] = cfg_data_i[BlW-1:0];
          RegBacklash2:  backlash_q[2] = cfg_data_i[BlW-1:0];
          RegBacklash3:  backlash_q[3] = cfg_data_i[BlW-1:0];
          default: ;
        endcase
      end
      // Compare each output transfer with the oldest block due
      if (out_valid_i && !out_stall_i) begin
        blocks_seen_o++;
        if (is_compensation_i) comp_seen_o++;
        if (blocks_due.size() == 0) begin
          $error("block transferred with none due (count_0 'h%0h)", count_0_i);
          mismatch_count_o++;
        end else begin
          blk = blocks_due.pop_front();
          check_field("is_compensation", PosW'(blk.comp), PosW'(is_compensation_i));
          check_field("count_0", blk.counts[0], count_0_i);
          check_field("count_1", blk.counts[1], count_1_i);
          check_field("count_2", blk.counts[2], count_2_i);
          check_field("count_3", blk.counts[3], count_3_i);
          check_field("direction_mask", PosW'(blk.dir), PosW'(direction_mask_i));
          check_field("longest_count", blk.longest, longest_count_i);
          check_field("lead_stepper", PosW'(blk.lead), PosW'(lead_stepper_i));
          check_field("last_of_run", PosW'(blk.last), PosW'(last_of_run_i));
        end
      end
      // Predict from each input transfer
      if (in_valid_i && !in_stall_i) begin
        split_into_blocks(opcode_i, {target_3_i, target_2_i, target_1_i, target_0_i});
      end
      blocks_due_o = blocks_due.size();
    end
  end

endmodule

[tb/step_delta_backlash_splitter_tb.sv]
// ----------------------------------------------------------------------------
// step_delta_backlash_splitter_tb
// Drives moves and syncs into the step delta splitter under several register
// settings, with random gaps on the input and random stalls on the output.
// A short directed run covers delta wrap, ties, direction flips, all-zero
// compensation and check mode; random phases follow. The checker beside the
// block predicts and compares every block; this module gives the verdict.
// ----------------------------------------------------------------------------
module step_delta_backlash_splitter_tb import sdb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NumSteppers-1:0][PosW-1:0] pos_vec_t;
  typedef logic [NumSteppers-1:0][BlW-1:0]  bl_vec_t;

  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned NumPhases     = 9;
  localparam int unsigned PhaseItems    = 148;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   opcode_i;
  logic [PosW-1:0]        target_0_i;
  logic [PosW-1:0]        target_1_i;
  logic [PosW-1:0]        target_2_i;
  logic [PosW-1:0]        target_3_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   is_compensation_o;
  logic [PosW-1:0]        count_0_o;
  logic [PosW-1:0]        count_1_o;
  logic [PosW-1:0]        count_2_o;
  logic [PosW-1:0]        count_3_o;
  logic [NumSteppers-1:0] direction_mask_o;
  logic [PosW-1:0]        longest_count_o;
  logic [LeadW-1:0]       lead_stepper_o;
  logic                   last_of_run_o;

  int unsigned mismatches;
  int unsigned blocks_due;
  int unsigned blocks_seen;
  int unsigned comp_seen;

  pos_vec_t    last_tgt;
  int unsigned moves_sent;
  int unsigned syncs_sent;
  bit          sender_idles;
  bit          receiver_stalls;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  step_delta_backlash_splitter dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .target_0_i,
    .target_1_i,
    .target_2_i,
    .target_3_i,
    .out_valid_o,
    .out_stall_i,
    .is_compensation_o,
    .count_0_o,
    .count_1_o,
    .count_2_o,
    .count_3_o,
    .direction_mask_o,
    .longest_count_o,
    .lead_stepper_o,
    .last_of_run_o
  );

  sdb_block_checker u_block_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i        (in_stall_o),
    .opcode_i,
    .target_0_i,
    .target_1_i,
    .target_2_i,
    .target_3_i,
    .out_valid_i       (out_valid_o),
    .out_stall_i,
    .is_compensation_i (is_compensation_o),
    .count_0_i         (count_0_o),
    .count_1_i         (count_1_o),
    .count_2_i         (count_2_o),
    .count_3_i         (count_3_o),
    .direction_mask_i  (direction_mask_o),
    .longest_count_i   (longest_count_o),
    .lead_stepper_i    (lead_stepper_o),
    .last_of_run_i     (last_of_run_o),
    .mismatch_count_o  (mismatches),
    .blocks_due_o      (blocks_due),
    .blocks_seen_o     (blocks_seen),
    .comp_seen_o       (comp_seen)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output stall: hold for a random stretch, then release
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
      out_stall_i <= 1'b1;
      stall_left  <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic pos_vec_t axes(input sdb_pos_t t0, input sdb_pos_t t1,
                                    input sdb_pos_t t2, input sdb_pos_t t3);
    return {t3, t2, t1, t0};
  endfunction

  // Next set of targets, shaped around the current position
  function automatic pos_vec_t next_targets(input pos_vec_t from);
    pos_vec_t    nxt;
    int unsigned kind;
    sdb_pos_t    step;
    kind = $urandom_range(0, 99);
    step = sdb_pos_t'($urandom_range(1, 1000));
    nxt  = from;
    for (int i = 0; i < NumSteppers; i++) begin
      if (kind < 40) begin
        // small moves with frequent direction flips
        if ($urandom_range(0, 3) != 0)
          nxt[i] = $urandom_range(0, 1) ? from[i] + sdb_pos_t'($urandom_range(1, 300))
                                        : from[i] - sdb_pos_t'($urandom_range(1, 300));
      end else if (kind < 55) begin
        // equal magnitudes to provoke ties
        if ($urandom_range(0, 1) != 0)
          nxt[i] = $urandom_range(0, 1) ? from[i] + step : from[i] - step;
      end else if (kind < 75) begin
        nxt[i] = $urandom;
      end else if (kind < 85) begin
        case ($urandom_range(0, 4))
          0:       nxt[i] = 32'h8000_0000;
          1:       nxt[i] = 32'h7FFF_FFFF;
          2:       nxt[i] = '0;
          3:       nxt[i] = '1;
          default: nxt[i] = from[i] + 32'h8000_0000;
        endcase
      end else begin
        nxt[i] = $urandom_range(0, 1) ? from[i] + sdb_pos_t'($urandom)
                                      : from[i] - sdb_pos_t'($urandom);
      end
    end
    return nxt;
  endfunction

  function automatic sdb_bl_t pick_backlash();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 45) return '1;
    if (r < 70) return sdb_bl_t'($urandom_range(1, 16));
    return sdb_bl_t'($urandom);
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_targets(input sdb_op_e op, input pos_vec_t tgt);
    int unsigned gap;
    opcode_i   <= op;
    target_0_i <= tgt[0];
    target_1_i <= tgt[1];
    target_2_i <= tgt[2];
    target_3_i <= tgt[3];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    last_tgt = tgt;
    if (op == OpSync) syncs_sent++;
    else moves_sent++;
    gap = sender_idles ? gap_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every block is out and the stages are empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (blocks_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write every register, then poke an index past the list
  task automatic configure(input logic chk, input logic en, input bl_vec_t steps);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegCheckMode;
    cfg_data_i  <= {(CfgDataW-1)'($urandom), chk};
    @(posedge clk_i);
    cfg_index_i <= RegBacklashEn;
    cfg_data_i  <= {(CfgDataW-1)'($urandom), en};
    @(posedge clk_i);
    for (int i = 0; i < NumSteppers; i++) begin
      cfg_index_i <= CfgIdxW'(RegBacklash0 + i);
      cfg_data_i  <= steps[i];
      @(posedge clk_i);
    end
    cfg_index_i <= CfgIdxW'(RegBacklash3 + 1 + $urandom_range(0, 1));
    cfg_data_i  <= CfgDataW'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    pos_vec_t    tgt;
    bl_vec_t     steps;
    logic        chk;
    logic        en;
    int unsigned r;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= RegCheckMode;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    opcode_i        <= OpMove;
    target_0_i      <= '0;
    target_1_i      <= '0;
    target_2_i      <= '0;
    target_3_i      <= '0;
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    moves_sent      = 0;
    syncs_sent      = 0;
    last_tgt        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers, plain moves, ties and delta wrap
    send_targets(OpMove, axes(5, -3, 0, 7));
    send_targets(OpMove, axes(5, -3, 0, 7));
    send_targets(OpMove, axes(15, -13, 10, 17));
    send_targets(OpSync, axes(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF));
    send_targets(OpMove, axes(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h7FFF_FFFF));
    send_targets(OpSync, axes(0, 0, 0, 0));
    settle();

    // Directed: direction flips, including one with all-zero compensation
    configure(1'b0, 1'b1, {16'h8000, 16'h0000, 16'h0001, 16'hFFFF});
    send_targets(OpMove, axes(-1, -1, -1, -1));
    send_targets(OpMove, axes(0, -2, -2, -2));
    send_targets(OpMove, axes(0, -2, -1, -2));
    send_targets(OpMove, axes(0, -2, -5, -2));
    send_targets(OpMove, axes(3, -2, -6, -2));
    settle();

    // Directed: check mode tracks positions only
    configure(1'b1, 1'b1, {16'h8000, 16'h0000, 16'h0001, 16'hFFFF});
    send_targets(OpMove, axes(100, 200, -300, 400));
    send_targets(OpSync, axes(1, 2, 3, 4));
    send_targets(OpMove, axes(-1, -2, -3, -4));
    settle();

    // Directed: tie among compensation counts
    configure(1'b0, 1'b1, {16'h0001, 16'h0001, 16'h0001, 16'h0001});
    send_targets(OpMove, axes(-1, -2, -3, -5));
    send_targets(OpMove, next_targets(last_tgt));
    settle();

    // Random phases, extremes of the registers first
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          chk   = 1'b0;
          en    = 1'b1;
          steps = '1;
        end
        1: begin
          chk   = 1'b0;
          en    = 1'b1;
          steps = '0;
        end
        2: begin
          chk = 1'b1;
          en  = 1'b1;
          for (int i = 0; i < NumSteppers; i++) steps[i] = pick_backlash();
        end
        default: begin
          chk = ($urandom_range(0, 99) < 15);
          en  = ($urandom_range(0, 99) < 70);
          for (int i = 0; i < NumSteppers; i++) steps[i] = pick_backlash();
        end
      endcase
      configure(chk, en, steps);
      // every third phase runs with no idling on either side
      sender_idles    = (p % 3 != 0);
      receiver_stalls = (p % 3 != 0);
      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_targets(OpSync, next_targets(last_tgt));
        end else if (r < 15) begin
          send_targets(OpMove, last_tgt);
        end else begin
          tgt = next_targets(last_tgt);
          send_targets(OpMove, tgt);
        end
        // hold the sender once mid-phase until the blocks drain
        if (p == 4 && n == PhaseItems / 2) settle();
      end
      settle();
    end

    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    $display("Run covered %0d moves and %0d syncs over %0d register settings,",
             moves_sent, syncs_sent, NumPhases + 4);
    $display("with %0d blocks compared, %0d of them compensation blocks.",
             blocks_seen, comp_seen);
    if (mismatches == 0 && blocks_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/sdb_pkg.sv
hdl/sdb_lane.sv
hdl/sdb_merge.sv
hdl/step_delta_backlash_splitter.sv
hdl/sdb_checker.sv
tb/sdb_block_checker.sv
tb/step_delta_backlash_splitter_tb.sv
